### hw/rtl/ptzfb_pkg.sv
package ptzfb_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] PELCO_LAST_POS = 4'd6;
    localparam logic [3:0] DRX_LAST_POS   = 4'd10;

    localparam logic       PROTO_DRX   = 1'b0;
    localparam logic       PROTO_PELCO = 1'b1;

    localparam logic       REG_PROTOCOL = 1'b0;
    localparam logic       REG_ADDRESS  = 1'b1;

    localparam logic [7:0] PELCO_SYNC   = 8'hFF;
    localparam logic [7:0] DRX_HEAD     = 8'h55;
    localparam logic [7:0] DRX_TAIL     = 8'hAA;
    localparam logic [7:0] DRX_CKS_BASE = 8'h20;
    localparam logic [7:0] PELCO_SPEED  = 8'h1B;
    localparam logic [7:0] DRX_PAN_SPD  = 8'hB0;
    localparam logic [7:0] DRX_TILT_SPD = 8'hBF;
    localparam logic [7:0] DRX_ZOOM_SPD = 8'h05;
    localparam logic [7:0] ROUND_PRESET = 8'h63;

    typedef enum logic [4:0] {
        CMD_STOP         = 5'd0,
        CMD_PAN_RIGHT    = 5'd1,
        CMD_PAN_LEFT     = 5'd2,
        CMD_TILT_UP      = 5'd3,
        CMD_TILT_DOWN    = 5'd4,
        CMD_ZOOM_IN      = 5'd5,
        CMD_ZOOM_OUT     = 5'd6,
        CMD_FOCUS_OUT    = 5'd7,
        CMD_FOCUS_IN     = 5'd8,
        CMD_ROUND        = 5'd9,
        CMD_RIGHT_UP     = 5'd10,
        CMD_RIGHT_DOWN   = 5'd11,
        CMD_LEFT_UP      = 5'd12,
        CMD_LEFT_DOWN    = 5'd13,
        CMD_LIGHT_ON     = 5'd14,
        CMD_LIGHT_OFF    = 5'd15,
        CMD_RAIN_ON      = 5'd16,
        CMD_RAIN_OFF     = 5'd17,
        CMD_APERTURE_OUT = 5'd18,
        CMD_APERTURE_IN  = 5'd19,
        CMD_PRESET_SET   = 5'd20,
        CMD_PRESET_GOTO  = 5'd21
    } cmd_t;

    typedef struct packed {
        logic                            pelco;
        logic [FRAME_BYTES-1:0][7:0]     frame;
    } frame_desc_t;

endpackage

### hw/rtl/ptzfb_front.sv
module ptzfb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [4:0]            command_code,
    input  logic [7:0]            preset_number,
    input  logic                  protocol,
    input  logic [7:0]            address,
    output logic                  desc_valid,
    input  logic                  desc_ready,
    output ptzfb_pkg::frame_desc_t desc
);
    import ptzfb_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    frame_desc_t desc_reg;
    frame_desc_t desc_next;
    logic        take;

    assign in_ready   = !valid_reg || desc_ready;
    assign take       = in_valid && in_ready;
    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

    // Pelco-D and DRX-500 payloads come from separate decoders; bytes that a
    // command does not set stay zero, which also covers unlisted codes.
    always_comb
    begin
        desc_next       = '0;
        desc_next.pelco = protocol;
        if (protocol == PROTO_PELCO)
        begin
            desc_next.frame[0] = PELCO_SYNC;
            desc_next.frame[1] = address;
            unique case (cmd_t'(command_code))
                CMD_PAN_RIGHT:
                begin
                    desc_next.frame[3] = 8'h02;
                    desc_next.frame[4] = PELCO_SPEED;
                end
                CMD_PAN_LEFT:
                begin
                    desc_next.frame[3] = 8'h04;
                    desc_next.frame[4] = PELCO_SPEED;
                end
                CMD_TILT_UP:
                begin
                    desc_next.frame[3] = 8'h08;
                    desc_next.frame[5] = PELCO_SPEED;
                end
                CMD_TILT_DOWN:
                begin
                    desc_next.frame[3] = 8'h10;
                    desc_next.frame[5] = PELCO_SPEED;
                end
                CMD_ZOOM_IN:      desc_next.frame[3] = 8'h20;
                CMD_ZOOM_OUT:     desc_next.frame[3] = 8'h40;
                CMD_FOCUS_OUT:    desc_next.frame[3] = 8'h80;
                CMD_FOCUS_IN:     desc_next.frame[2] = 8'h01;
                CMD_ROUND:
                begin
                    desc_next.frame[3] = 8'h07;
                    desc_next.frame[5] = ROUND_PRESET;
                end
                CMD_RIGHT_UP:
                begin
                    desc_next.frame[3] = 8'h0A;
                    desc_next.frame[4] = PELCO_SPEED;
                    desc_next.frame[5] = PELCO_SPEED;
                end
                CMD_RIGHT_DOWN:
                begin
                    desc_next.frame[3] = 8'h12;
                    desc_next.frame[4] = PELCO_SPEED;
                    desc_next.frame[5] = PELCO_SPEED;
                end
                CMD_LEFT_UP:
                begin
                    desc_next.frame[3] = 8'h0C;
                    desc_next.frame[4] = PELCO_SPEED;
                    desc_next.frame[5] = PELCO_SPEED;
                end
                CMD_LEFT_DOWN:
                begin
                    desc_next.frame[3] = 8'h14;
                    desc_next.frame[4] = PELCO_SPEED;
                    desc_next.frame[5] = PELCO_SPEED;
                end
                CMD_LIGHT_ON:
                begin
                    desc_next.frame[3] = 8'h09;
                    desc_next.frame[5] = 8'h02;
                end
                CMD_LIGHT_OFF:
                begin
                    desc_next.frame[3] = 8'h0B;
                    desc_next.frame[5] = 8'h02;
                end
                CMD_RAIN_ON:
                begin
                    desc_next.frame[3] = 8'h09;
                    desc_next.frame[5] = 8'h01;
                end
                CMD_RAIN_OFF:
                begin
                    desc_next.frame[3] = 8'h0B;
                    desc_next.frame[5] = 8'h01;
                end
                CMD_APERTURE_OUT: desc_next.frame[2] = 8'h04;
                CMD_APERTURE_IN:  desc_next.frame[2] = 8'h02;
                CMD_PRESET_SET:
                begin
                    desc_next.frame[3] = 8'h03;
                    desc_next.frame[5] = preset_number;
                end
                CMD_PRESET_GOTO:
                begin
                    desc_next.frame[3] = 8'h07;
                    desc_next.frame[5] = preset_number;
                end
                default: ;
            endcase
        end
        else
        begin
            desc_next.frame[0] = DRX_HEAD;
            desc_next.frame[2] = address;
            desc_next.frame[9] = DRX_TAIL;
            unique case (cmd_t'(command_code))
                CMD_PAN_RIGHT:
                begin
                    desc_next.frame[4] = 8'h02;
                    desc_next.frame[5] = DRX_PAN_SPD;
                end
                CMD_PAN_LEFT:
                begin
                    desc_next.frame[4] = 8'h04;
                    desc_next.frame[5] = DRX_PAN_SPD;
                end
                CMD_TILT_UP:
                begin
                    desc_next.frame[4] = 8'h08;
                    desc_next.frame[6] = DRX_TILT_SPD;
                end
                CMD_TILT_DOWN:
                begin
                    desc_next.frame[4] = 8'h10;
                    desc_next.frame[6] = DRX_TILT_SPD;
                end
                CMD_ZOOM_IN:
                begin
                    desc_next.frame[4] = 8'h20;
                    desc_next.frame[7] = DRX_ZOOM_SPD;
                end
                CMD_ZOOM_OUT:
                begin
                    desc_next.frame[4] = 8'h40;
                    desc_next.frame[7] = DRX_ZOOM_SPD;
                end
                CMD_FOCUS_OUT:
                begin
                    desc_next.frame[3] = 8'h01;
                    desc_next.frame[7] = DRX_ZOOM_SPD;
                end
                CMD_FOCUS_IN:
                begin
                    desc_next.frame[3] = 8'h02;
                    desc_next.frame[7] = DRX_ZOOM_SPD;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (desc_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            desc_reg <= desc_next;
        end
    end

endmodule

### hw/rtl/ptzfb_queue.sv
module ptzfb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  ptzfb_pkg::frame_desc_t wr_desc,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output ptzfb_pkg::frame_desc_t rd_desc
);
    import ptzfb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_desc_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push;
    logic                pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Queue count did not follow a push.");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Empty queue has unequal pointers.");
`endif

endmodule

### hw/rtl/ptzfb_back.sv
module ptzfb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  desc_valid,
    output logic                  desc_ready,
    input  ptzfb_pkg::frame_desc_t desc,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            frame_byte,
    output logic [3:0]            byte_position,
    output logic                  last_byte
);
    import ptzfb_pkg::*;

    frame_desc_t desc_reg;
    logic        busy_reg;
    logic        busy_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  acc_reg;
    logic [7:0]  acc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic [3:0]  position_reg;
    logic        last_reg;
    logic        advance;
    logic        at_last;
    logic        load;
    logic [7:0]  checksum;
    logic [7:0]  byte_sel;

    assign advance    = !out_valid_reg || out_ready;
    assign at_last    = (pos_reg == (desc_reg.pelco ? PELCO_LAST_POS : DRX_LAST_POS));
    assign desc_ready = advance && (!busy_reg || at_last);
    assign load       = desc_ready && desc_valid;

    // The running sum covers every byte before the checksum. Pelco-D leaves
    // out the sync byte, so 0xFF is taken back off by adding one.
    assign checksum = desc_reg.pelco ? acc_reg + 8'd1 : DRX_CKS_BASE - acc_reg;
    assign byte_sel = at_last ? checksum : desc_reg.frame[pos_reg];

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                pos_next = pos_reg + 4'd1;
                acc_next = acc_reg + byte_sel;
                if (at_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load)
        begin
            desc_reg <= desc;
        end
        if (advance && busy_reg)
        begin
            byte_reg     <= byte_sel;
            position_reg <= pos_reg;
            last_reg     <= at_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = byte_reg;
    assign byte_position = position_reg;
    assign last_byte     = last_reg;

`ifndef SYNTHESIS
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_byte) |-> (byte_position == PELCO_LAST_POS ||
                                      byte_position == DRX_LAST_POS))
        else $error("Frame ends at a position that no protocol uses.");

    a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_byte) |=>
            (out_valid && byte_position == $past(byte_position) + 4'd1))
        else $error("Frame bytes are not contiguous.");

    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_position == 4'd0) |->
            (frame_byte == PELCO_SYNC || frame_byte == DRX_HEAD))
        else $error("Frame does not start with a header byte.");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= DRX_LAST_POS))
        else $error("Byte counter ran past the frame.");
`endif

endmodule

### hw/rtl/ptz_command_frame_builder.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     command_code[4:0], preset_number[7:0]
// cfg      cfg_valid / cfg_ready   cfg_index[0], cfg_data[7:0]
// out      out_valid / out_ready   frame_byte[7:0], byte_position[3:0], last_byte
//
// A transaction gives 7 Pelco-D or 11 DRX-500 bytes, one byte per cycle if out_ready is high.
// The output byte counter sets the sustained rate; frames follow without a gap.
// From idle, a command goes through the front register, a queue entry and the output registers.
// Reset selects Pelco-D with camera address 1; cfg_ready is always high.
// A two-entry queue and a front register let input transactions proceed while out_ready is low.
module ptz_command_frame_builder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] command_code,
    input  logic [7:0] preset_number,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic [3:0] byte_position,
    output logic       last_byte
);
    import ptzfb_pkg::*;

    logic        protocol_reg;
    logic        protocol_next;
    logic [7:0]  address_reg;
    logic [7:0]  address_next;
    logic        front_valid;
    logic        front_ready;
    frame_desc_t front_desc;
    logic        queue_valid;
    logic        queue_ready;
    frame_desc_t queue_desc;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        protocol_next = protocol_reg;
        address_next  = address_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PROTOCOL: protocol_next = cfg_data[0];
                REG_ADDRESS:  address_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_reg <= PROTO_PELCO;
            address_reg  <= 8'd1;
        end
        else
        begin
            protocol_reg <= protocol_next;
            address_reg  <= address_next;
        end
    end

    ptzfb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command_code  (command_code),
        .preset_number (preset_number),
        .protocol      (protocol_reg),
        .address       (address_reg),
        .desc_valid    (front_valid),
        .desc_ready    (front_ready),
        .desc          (front_desc)
    );

    ptzfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_desc  (front_desc),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_desc  (queue_desc)
    );

    ptzfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .desc_valid    (queue_valid),
        .desc_ready    (queue_ready),
        .desc          (queue_desc),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte)
    );

endmodule
